FILE: rtl/core/mur_pkg.sv
package mur_pkg;

  localparam int CHAN_W = 2;
  localparam int DIST_W = 15;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int SETTLE_W = 8;
  localparam int TRIG_W = 8;
  localparam int GAP_W = 20;

  // floor(x / 29) as (x * DIV_MULT) >> DIV_SHIFT, exact for x < 2^20;
  // the extra factor 8 is folded into the shift.
  localparam int DIV_MULT_W = 24;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 24'd9256396;
  localparam int DIV_SHIFT = 25;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TRIG = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAP = 2'd2;

  localparam logic [SETTLE_W-1:0] SETTLE_RST = 8'd1;
  localparam logic [TRIG_W-1:0] TRIG_RST = 8'd10;
  localparam logic [GAP_W-1:0] GAP_RST = 20'd60000;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_time;
    logic [TRIG_W-1:0] trigger_width;
    logic [GAP_W-1:0] gap_time;
  } cfg_t;

endpackage

FILE: rtl/core/mur_tick_if.sv
interface mur_tick_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

FILE: rtl/core/mur_result_if.sv
interface mur_result_if;
  logic valid;
  logic ready;
  logic trigger;
  logic [mur_pkg::CHAN_W-1:0] channel_select;
  logic distance_valid;
  logic [mur_pkg::CHAN_W-1:0] distance_channel;
  logic [mur_pkg::DIST_W-1:0] distance;

  modport source (output valid, output trigger, output channel_select,
                  output distance_valid, output distance_channel,
                  output distance, input ready);
  modport sink (input valid, input trigger, input channel_select,
                input distance_valid, input distance_channel,
                input distance, output ready);
endinterface

FILE: rtl/core/mur_dist.sv
module mur_dist #(
  parameter int ECHO_COUNT_BITS = 16
) (
  input  logic [ECHO_COUNT_BITS-1:0]   echo_count,
  output logic [mur_pkg::DIST_W-1:0]   distance
);

  localparam int PROD_W = ECHO_COUNT_BITS + mur_pkg::DIV_MULT_W;
  localparam int QUO_W = PROD_W - mur_pkg::DIV_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0] quo;
  logic [31:0] quo_ext;

  assign prod = PROD_W'(echo_count) * PROD_W'(mur_pkg::DIV_MULT);
  assign quo = prod[PROD_W-1:mur_pkg::DIV_SHIFT];
  assign quo_ext = 32'(quo);
  assign distance = (quo_ext > 32'(mur_pkg::DIST_MAX)) ? mur_pkg::DIST_MAX
                                                       : quo_ext[mur_pkg::DIST_W-1:0];

endmodule

FILE: rtl/core/multiplexed_ultrasonic_ranger.sv
// Multiplexed ultrasonic ranger.
// Each request on the tick channel is one microsecond tick carrying the
// sampled echo level. For every tick the block returns one request on the
// result channel: trigger level and mux select in force during that tick,
// and, on a falling echo edge, the distance (cm, 4 fraction bits) of the
// selected sensor. Sensors are visited round-robin: settle, trigger, gap.
// Timing registers (settle_time, trigger_width, gap_time) sit on the APB
// port at byte addresses 0, 4, 8; write them only while idle.
// A tick's result is registered, shown after the accepting edge; one tick
// per cycle unless the receiver stalls, set by the single result register.
// The tick channel stays ready while the result register is empty or being
// taken; when the receiver stalls, the result holds and ticks back up.
// Reset (synchronous, rst high) returns to the settle phase of channel 0,
// clears the echo counter and edge history, and restores register defaults.
module multiplexed_ultrasonic_ranger #(
  parameter int NUM_CHANNELS = 4,
  parameter int ECHO_COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  mur_tick_if.sink                     tick,
  mur_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mur_pkg::ADDR_W-1:0]   paddr,
  input  logic [mur_pkg::DATA_W-1:0]   pwdata,
  output logic [mur_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int PH_W = 2;
  localparam logic [PH_W-1:0] PH_SETTLE = 2'd0;
  localparam logic [PH_W-1:0] PH_TRIGGER = 2'd1;
  localparam logic [PH_W-1:0] PH_GAP = 2'd2;
  localparam int CW = mur_pkg::CHAN_W;
  localparam int GW = mur_pkg::GAP_W;

  mur_pkg::cfg_t cfg;

  logic [PH_W-1:0] phase, phase_next;
  logic [GW-1:0] phase_counter, phase_counter_next;
  logic [CW-1:0] current_channel, current_channel_next;
  logic [ECHO_COUNT_BITS-1:0] echo_time, echo_time_next;
  logic echo_previous;

  logic out_valid;
  logic out_trigger;
  logic [CW-1:0] out_channel_select;
  logic out_distance_valid;
  logic [CW-1:0] out_distance_channel;
  logic [mur_pkg::DIST_W-1:0] out_distance;

  logic accept;
  logic cfg_wr;
  logic [mur_pkg::REG_IDX_W-1:0] reg_idx;
  logic [PH_W-1:0] ph_eff;
  logic [GW-1:0] cnt_eff, cnt_inc, len;
  logic rising, falling;
  logic [mur_pkg::DIST_W-1:0] dist_calc;

  // APB
  assign pready = 1'b1;
  assign reg_idx = paddr[mur_pkg::ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      mur_pkg::REG_SETTLE: prdata = mur_pkg::DATA_W'(cfg.settle_time);
      mur_pkg::REG_TRIG:   prdata = mur_pkg::DATA_W'(cfg.trigger_width);
      mur_pkg::REG_GAP:    prdata = mur_pkg::DATA_W'(cfg.gap_time);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_time <= mur_pkg::SETTLE_RST;
      cfg.trigger_width <= mur_pkg::TRIG_RST;
      cfg.gap_time <= mur_pkg::GAP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mur_pkg::REG_SETTLE: cfg.settle_time <= pwdata[mur_pkg::SETTLE_W-1:0];
        mur_pkg::REG_TRIG:   cfg.trigger_width <= pwdata[mur_pkg::TRIG_W-1:0];
        mur_pkg::REG_GAP:    cfg.gap_time <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign tick.ready = !out_valid || result.ready;
  assign accept = tick.valid && tick.ready;

  // sequencer
  always_comb begin
    ph_eff = (phase == PH_TRIGGER || phase == PH_GAP) ? phase : PH_SETTLE;
    cnt_eff = phase_counter;
    if (ph_eff == PH_SETTLE && cfg.settle_time == '0) begin
      ph_eff = PH_TRIGGER;
      cnt_eff = '0;
    end

    unique case (ph_eff)
      PH_TRIGGER: len = GW'(cfg.trigger_width);
      PH_GAP:     len = cfg.gap_time;
      default:    len = GW'(cfg.settle_time);
    endcase
    if (len == '0) begin
      len = GW'(1);
    end

    cnt_inc = cnt_eff + GW'(1);
    phase_next = ph_eff;
    phase_counter_next = cnt_inc;
    current_channel_next = current_channel;
    if (cnt_inc >= len || cnt_inc == '0) begin
      phase_counter_next = '0;
      unique case (ph_eff)
        PH_SETTLE:  phase_next = PH_TRIGGER;
        PH_TRIGGER: phase_next = PH_GAP;
        default: begin
          phase_next = PH_SETTLE;
          if ((3'(current_channel) + 3'd1) >= 3'(NUM_CHANNELS)) begin
            current_channel_next = '0;
          end else begin
            current_channel_next = current_channel + CW'(1);
          end
        end
      endcase
    end
  end

  // echo timing
  assign rising = tick.echo_level && !echo_previous;
  assign falling = !tick.echo_level && echo_previous;

  always_comb begin
    if (rising) begin
      echo_time_next = '0;
    end else if (&echo_time) begin
      echo_time_next = echo_time;
    end else begin
      echo_time_next = echo_time + ECHO_COUNT_BITS'(1);
    end
  end

  mur_dist #(
    .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
  ) u_dist (
    .echo_count(echo_time_next),
    .distance(dist_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SETTLE;
      phase_counter <= '0;
      current_channel <= '0;
      echo_time <= '0;
      echo_previous <= 1'b0;
      out_valid <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      phase_counter <= phase_counter_next;
      current_channel <= current_channel_next;
      echo_time <= echo_time_next;
      echo_previous <= tick.echo_level;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_trigger <= (ph_eff == PH_TRIGGER);
      out_channel_select <= current_channel;
      out_distance_valid <= falling;
      out_distance_channel <= falling ? current_channel : '0;
      out_distance <= falling ? dist_calc : '0;
    end
  end

  assign result.valid = out_valid;
  assign result.trigger = out_trigger;
  assign result.channel_select = out_channel_select;
  assign result.distance_valid = out_distance_valid;
  assign result.distance_channel = out_distance_channel;
  assign result.distance = out_distance;

endmodule
